// File: design/neighbor_outlier_split_3x3_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for neighbor_outlier_split_3x3
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_OUTLIER_SPLIT_3X3_MACROS_SVH
`define NEIGHBOR_OUTLIER_SPLIT_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define NOS_ASSERT(lbl, prop, msg)
`define NOS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/nos_pkg.sv
// ----------------------------------------------------------------------------
// nos_pkg
// Shared constants and types of the 3x3 neighbor outlier splitter.
// ----------------------------------------------------------------------------
package nos_pkg;

  localparam int FaceSizeDef   = 2048;
  localparam int ChannelBitsDef = 32;
  localparam int FaceCfgW      = 12;
  localparam int FaceRst       = 2048;
  localparam int MinFace       = 2;
  localparam int FracBits      = 16;
  localparam int QDepth        = 2;

  typedef enum logic [3:0] {
    BkIdle,
    BkLoad,
    BkSum,
    BkDen,
    BkChk,
    BkDiv,
    BkMul,
    BkStore,
    BkOut
  } nos_bk_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } nos_q_status_t;

endpackage

// File: design/nos_in_if.sv
// ----------------------------------------------------------------------------
// nos_in_if
// Pixel / flush input channel with valid-ready handshake.
// ----------------------------------------------------------------------------
interface nos_in_if #(
  parameter int CB = 32
);
  logic          valid;
  logic          ready;
  logic          func;
  logic          start_of_face;
  logic [CB-1:0] pixel_x;
  logic [CB-1:0] pixel_y;
  logic [CB-1:0] pixel_z;

  modport source (output valid, func, start_of_face, pixel_x, pixel_y, pixel_z,
                  input ready);
  modport sink (input valid, func, start_of_face, pixel_x, pixel_y, pixel_z,
                output ready);
endinterface

// File: design/nos_out_if.sv
// ----------------------------------------------------------------------------
// nos_out_if
// Result channel carrying galaxy and star parts of one pixel.
// ----------------------------------------------------------------------------
interface nos_out_if #(
  parameter int CB = 32
);
  logic          valid;
  logic          ready;
  logic [CB-1:0] galaxy_x;
  logic [CB-1:0] galaxy_y;
  logic [CB-1:0] galaxy_z;
  logic [CB-1:0] star_x;
  logic [CB-1:0] star_y;
  logic [CB-1:0] star_z;
  logic          is_outlier;
  logic          last_of_face;

  modport source (output valid, galaxy_x, galaxy_y, galaxy_z, star_x, star_y, star_z,
                  is_outlier, last_of_face, input ready);
  modport sink (input valid, galaxy_x, galaxy_y, galaxy_z, star_x, star_y, star_z,
                is_outlier, last_of_face, output ready);
endinterface

// File: design/nos_cfg_if.sv
// ----------------------------------------------------------------------------
// nos_cfg_if
// Configuration write channel for the face side register.
// ----------------------------------------------------------------------------
interface nos_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [nos_pkg::FaceCfgW-1:0] face_size;

  modport source (output valid, face_size, input ready);
  modport sink (input valid, face_size, output ready);
endinterface

// File: design/neighbor_outlier_split_3x3.sv
// ----------------------------------------------------------------------------
// neighbor_outlier_split_3x3
// Star/galaxy split of XYZ pixels by 3x3 neighbor luminance average.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    func, start_of_face, pixel_x/y/z
//  cfg_ch    in   valid/ready    face_size
//  out_ch    out  valid/ready    galaxy_x/y/z, star_x/y/z, is_outlier, last_of_face
//
//  Front takes one transaction per cycle while the 2-entry command queue has room.
//  Back unit: takes a new command only when idle, once it is through with the last one;
//  a result needs a neighbor sum over the 3x3 window cells, a 16-step fraction divider
//  for an outlier, and 3 multiply/store pairs through one multiplier.
//  Results lag input by one row plus one pixel; flush transactions drain the tail.
//  Reset is asynchronous; no clearing pass. Output stalls back up through the queue.
// ----------------------------------------------------------------------------
`include "neighbor_outlier_split_3x3_macros.svh"

module neighbor_outlier_split_3x3 #(
  parameter int FACE_SIZE    = nos_pkg::FaceSizeDef,
  parameter int CHANNEL_BITS = nos_pkg::ChannelBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nos_in_if.sink    in_ch,
  nos_cfg_if.sink   cfg_ch,
  nos_out_if.source out_ch
);
  import nos_pkg::*;

  localparam int CMDW = 2*$clog2(FACE_SIZE+2) + $clog2(FACE_SIZE) + 3*CHANNEL_BITS;

  logic            q_push, q_pop;
  logic [CMDW-1:0] q_wdata, q_rdata;
  nos_q_status_t   q_status;

  nos_front #(.FACE_SIZE(FACE_SIZE), .CB(CHANNEL_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_status_i (q_status),
    .push_o     (q_push),
    .cmd_o      (q_wdata)
  );

  nos_fifo #(.W(CMDW)) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  nos_back #(.FACE_SIZE(FACE_SIZE), .CB(CHANNEL_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .cmd_i      (q_rdata),
    .pop_o      (q_pop),
    .out_ch     (out_ch)
  );

  `NOS_ASSERT(a_q_no_overflow, q_push |-> !q_status.full, "command queue overflow")
  `NOS_ASSERT(a_q_no_underflow, q_pop |-> !q_status.empty, "command queue underflow")
  `NOS_ASSERT_NEXT(a_q_fill, (q_push && !q_pop), !q_status.empty, "queue lost a command")
  `NOS_ASSERT(a_star_zero, (out_ch.valid && !out_ch.is_outlier) |-> (out_ch.star_x == '0 && out_ch.star_y == '0 && out_ch.star_z == '0), "star part on non-outlier")

endmodule

// File: design/nos_front.sv
// ----------------------------------------------------------------------------
// nos_front
// Accepts transactions, tracks face position and drain, issues step commands.
// ----------------------------------------------------------------------------
module nos_front #(
  parameter int FACE_SIZE = nos_pkg::FaceSizeDef,
  parameter int CB        = nos_pkg::ChannelBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  nos_in_if.sink                 in_ch,
  nos_cfg_if.sink                cfg_ch,
  input  nos_pkg::nos_q_status_t q_status_i,
  output logic                   push_o,
  output logic [2*$clog2(FACE_SIZE+2)+$clog2(FACE_SIZE)+3*CB-1:0] cmd_o
);
  import nos_pkg::*;

  localparam int PW     = $clog2(FACE_SIZE+2);
  localparam int AW     = $clog2(FACE_SIZE);
  localparam int XW     = (PW > FaceCfgW) ? PW : FaceCfgW;
  localparam int SideRst = (FaceRst > FACE_SIZE) ? FACE_SIZE : FaceRst;

  logic [FaceCfgW-1:0] face_q;
  logic [PW-1:0]       side_q, side_d;
  logic [PW-1:0]       row_q, row_d;
  logic [AW-1:0]       col_q, col_d;
  logic [PW-1:0]       pend_q, pend_d;

  logic [XW-1:0] face_x;
  logic [PW-1:0] face_cl;
  logic          in_fire, restart, push;
  logic [PW-1:0] n_eff, row_eff, pend_eff, col_nx, drain_pos;
  logic [AW-1:0] col_eff;
  logic [PW-1:0] cr, cn;
  logic [AW-1:0] cc;
  logic [CB-1:0] cy, cx, cz;

  assign in_ch.ready  = !q_status_i.full;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid & in_ch.ready;

  assign face_x  = XW'(face_q);
  assign face_cl = (face_x < XW'(MinFace))   ? PW'(MinFace)   :
                   (face_x > XW'(FACE_SIZE)) ? PW'(FACE_SIZE) : PW'(face_x);

  assign restart  = !in_ch.func && (in_ch.start_of_face || (row_q == '0 && col_q == '0));
  assign n_eff    = restart ? face_cl : side_q;
  assign row_eff  = restart ? '0 : row_q;
  assign col_eff  = restart ? '0 : col_q;
  assign pend_eff = restart ? '0 : pend_q;
  assign col_nx   = PW'(col_eff) + PW'(1);
  assign drain_pos = side_q + PW'(1) - pend_q;

  always_comb begin
    side_d = side_q;
    row_d  = row_q;
    col_d  = col_q;
    pend_d = pend_q;
    push   = 1'b0;
    cr     = row_eff;
    cc     = col_eff;
    cn     = n_eff;
    cy     = in_ch.pixel_y;
    cx     = in_ch.pixel_x;
    cz     = in_ch.pixel_z;
    if (in_fire) begin
      if (!in_ch.func) begin
        side_d = n_eff;
        row_d  = row_eff;
        col_d  = col_eff;
        pend_d = pend_eff;
        if (row_eff < n_eff) begin
          push = 1'b1;
          if (col_nx >= n_eff) begin
            col_d = '0;
            row_d = row_eff + PW'(1);
            if (row_eff + PW'(1) >= n_eff) begin
              pend_d = n_eff + PW'(1);
            end
          end else begin
            col_d = AW'(col_nx);
          end
        end
      end else if (pend_q != '0 && row_q >= side_q) begin
        push   = 1'b1;
        pend_d = pend_q - PW'(1);
        cn     = side_q;
        cy     = '0;
        cx     = '0;
        cz     = '0;
        if (drain_pos < side_q) begin
          cr = side_q;
          cc = AW'(drain_pos);
        end else begin
          cr = side_q + PW'(1);
          cc = '0;
        end
      end
    end
  end

  assign push_o = push;
  assign cmd_o  = {cr, cc, cn, cy, cx, cz};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q <= FaceCfgW'(FaceRst);
      side_q <= PW'(SideRst);
      row_q  <= '0;
      col_q  <= '0;
      pend_q <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        face_q <= cfg_ch.face_size;
      end
      side_q <= side_d;
      row_q  <= row_d;
      col_q  <= col_d;
      pend_q <= pend_d;
    end
  end

endmodule

// File: design/nos_fifo.sv
// ----------------------------------------------------------------------------
// nos_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module nos_fifo #(
  parameter int W = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [W-1:0]           data_i,
  input  logic                   pop_i,
  output logic [W-1:0]           data_o,
  output nos_pkg::nos_q_status_t status_o
);
  import nos_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth+1);

  logic [W-1:0]    mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign data_o          = mem_q[rd_q];
  assign status_o.full   = (cnt_q == CntW'(QDepth));
  assign status_o.empty  = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: design/nos_back.sv
// ----------------------------------------------------------------------------
// nos_back
// Line buffers, 3x3 window, neighbor sum, fraction divider and split.
// ----------------------------------------------------------------------------
module nos_back #(
  parameter int FACE_SIZE = nos_pkg::FaceSizeDef,
  parameter int CB        = nos_pkg::ChannelBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nos_pkg::nos_q_status_t q_status_i,
  input  logic [2*$clog2(FACE_SIZE+2)+$clog2(FACE_SIZE)+3*CB-1:0] cmd_i,
  output logic                   pop_o,
  nos_out_if.source              out_ch
);
  import nos_pkg::*;

  localparam int PW   = $clog2(FACE_SIZE+2);
  localparam int AW   = $clog2(FACE_SIZE);
  localparam int CMDW = 2*PW + AW + 3*CB;
  localparam int SW   = CB + 3;
  localparam int DNW  = CB + 4;
  localparam int DW   = CB + 5;
  localparam int FW   = FracBits + 1;
  localparam int PRW  = CB + FW;

  nos_bk_state_e st_q, st_d;

  logic [4*CB-1:0] lb_mem [FACE_SIZE];
  logic [4*CB-1:0] rd_q;

  logic [PW-1:0] cmd_r, cmd_n;
  logic [AW-1:0] cmd_c;

  logic [PW-1:0] r_q, n_q;
  logic [AW-1:0] c_q;
  logic [CB-1:0] y_q, x_q, z_q, rx_q, rz_q;
  logic [CB-1:0] win_q [3][3];
  logic [CB-1:0] hold_x_q, hold_z_q;
  logic          rlo_q, rhi_q, clo_q, chi_q, last_q, outl_q;
  logic [1:0]    sr_q, sc_q, ch_q;
  logic [SW-1:0] sum_q;
  logic [3:0]    cnt_q, dcnt_q;
  logic [DNW-1:0] den_q;
  logic [DW-1:0]  rem_q;
  logic [FW-1:0]  f_q;
  logic [PRW-1:0] prod_q;
  logic [CB-1:0]  star_q [3];
  logic [CB-1:0]  gal_q [3];
  logic           out_valid_q;

  logic [CB-1:0] up_w, mid_w, rx_w, rz_w, cell_w, ch_sel, star_w;
  logic          em_a, em_b, row_ok, col_ok, cell_in, outl_c, out_load;
  logic [DW-1:0] rem2;

  assign cmd_r = cmd_i[CMDW-1 -: PW];
  assign cmd_c = cmd_i[CMDW-PW-1 -: AW];
  assign cmd_n = cmd_i[CMDW-PW-AW-1 -: PW];

  assign {up_w, mid_w, rx_w, rz_w} = rd_q;

  assign em_a = (c_q == '0) && (r_q >= PW'(2));
  assign em_b = (c_q != '0) && (r_q >= PW'(1));

  assign cell_w  = win_q[sr_q][sc_q];
  assign row_ok  = (sr_q == 2'd1) || (sr_q == 2'd0 && rlo_q) || (sr_q == 2'd2 && rhi_q);
  assign col_ok  = (sc_q == 2'd1) || (sc_q == 2'd0 && clo_q) || (sc_q == 2'd2 && chi_q);
  assign cell_in = row_ok && col_ok && !(sr_q == 2'd1 && sc_q == 2'd1);

  assign outl_c = den_q > {sum_q, 1'b0};
  assign rem2   = {rem_q[DW-2:0], 1'b0};

  assign ch_sel = (ch_q == 2'd0) ? hold_x_q : (ch_q == 2'd1) ? win_q[1][1] : hold_z_q;
  assign star_w = prod_q[CB+FracBits-1:FracBits];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle:  if (!q_status_i.empty) st_d = BkLoad;
      BkLoad:  st_d = (em_a || em_b) ? BkSum : BkIdle;
      BkSum:   if (sr_q == 2'd2 && sc_q == 2'd2) st_d = BkDen;
      BkDen:   st_d = BkChk;
      BkChk:   st_d = outl_c ? BkDiv : BkMul;
      BkDiv:   if (dcnt_q == 4'(FracBits-1)) st_d = BkMul;
      BkMul:   st_d = BkStore;
      BkStore: st_d = (ch_q == 2'd2) ? BkOut : BkMul;
      BkOut:   if (!out_valid_q || out_ch.ready) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  // outputs
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (st_q)
      BkIdle:  pop_o = !q_status_i.empty;
      BkOut:   out_load = !out_valid_q || out_ch.ready;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q <= lb_mem[cmd_c];
    end
    if (st_q == BkLoad) begin
      lb_mem[c_q] <= {mid_w, y_q, x_q, z_q};
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      BkIdle: begin
        r_q <= cmd_r;
        c_q <= cmd_c;
        n_q <= cmd_n;
        y_q <= cmd_i[3*CB-1 -: CB];
        x_q <= cmd_i[2*CB-1 -: CB];
        z_q <= cmd_i[CB-1:0];
      end
      BkLoad: begin
        rx_q  <= rx_w;
        rz_q  <= rz_w;
        sum_q <= '0;
        cnt_q <= '0;
        sr_q  <= '0;
        sc_q  <= '0;
        if (em_a) begin
          rlo_q  <= r_q >= PW'(3);
          rhi_q  <= r_q <= n_q;
          clo_q  <= 1'b1;
          chi_q  <= 1'b0;
          last_q <= r_q == (n_q + PW'(1));
        end else begin
          rlo_q  <= r_q >= PW'(2);
          rhi_q  <= r_q < n_q;
          clo_q  <= c_q >= AW'(2);
          chi_q  <= 1'b1;
          last_q <= 1'b0;
        end
      end
      BkSum: begin
        if (cell_in) begin
          sum_q <= sum_q + SW'(cell_w);
          cnt_q <= cnt_q + 4'd1;
        end
        if (sc_q == 2'd2) begin
          sc_q <= '0;
          sr_q <= sr_q + 2'd1;
        end else begin
          sc_q <= sc_q + 2'd1;
        end
      end
      BkDen: begin
        den_q <= DNW'(win_q[1][1]) * DNW'(cnt_q);
      end
      BkChk: begin
        outl_q <= outl_c;
        dcnt_q <= '0;
        ch_q   <= '0;
        if (outl_c) begin
          rem_q <= (sum_q == '0) ? '0 : DW'(den_q) - DW'(sum_q);
          f_q   <= (sum_q == '0) ? FW'(1) : '0;
        end else begin
          f_q <= '0;
        end
      end
      BkDiv: begin
        dcnt_q <= dcnt_q + 4'd1;
        if (rem2 >= DW'(den_q)) begin
          rem_q <= rem2 - DW'(den_q);
          f_q   <= {f_q[FW-2:0], 1'b1};
        end else begin
          rem_q <= rem2;
          f_q   <= {f_q[FW-2:0], 1'b0};
        end
      end
      BkMul: begin
        prod_q <= PRW'(ch_sel) * PRW'(f_q);
      end
      BkStore: begin
        star_q[ch_q] <= star_w;
        gal_q[ch_q]  <= ch_sel - star_w;
        ch_q         <= ch_q + 2'd1;
      end
      BkOut: begin
        if (out_load) begin
          out_ch.galaxy_x     <= gal_q[0];
          out_ch.galaxy_y     <= gal_q[1];
          out_ch.galaxy_z     <= gal_q[2];
          out_ch.star_x       <= star_q[0];
          out_ch.star_y       <= star_q[1];
          out_ch.star_z       <= star_q[2];
          out_ch.is_outlier   <= outl_q;
          out_ch.last_of_face <= last_q;
        end
      end
      default: begin
        ch_q <= '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BkIdle;
      out_valid_q <= 1'b0;
      hold_x_q    <= '0;
      hold_z_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (st_q == BkLoad) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= up_w;
        win_q[1][2] <= mid_w;
        win_q[2][2] <= y_q;
        if (!(em_a || em_b)) begin
          hold_x_q <= rx_w;
          hold_z_q <= rz_w;
        end
      end
      if (out_load) begin
        hold_x_q <= rx_q;
        hold_z_q <= rz_q;
      end
    end
  end

  assign out_ch.valid = out_valid_q;

endmodule
